FILE: rtl/jts_pkg.sv
// Shared types and constants for the JSON token scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jts_pkg;

  // Defaults for the top-level parameters.
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Most results that one text byte can cause.
  localparam int MAX_RESULTS = 3;

  // Token kinds.
  localparam logic [3:0] KIND_OBJ_START = 4'd0;
  localparam logic [3:0] KIND_OBJ_END   = 4'd1;
  localparam logic [3:0] KIND_ARR_START = 4'd2;
  localparam logic [3:0] KIND_ARR_END   = 4'd3;
  localparam logic [3:0] KIND_COLON     = 4'd4;
  localparam logic [3:0] KIND_COMMA     = 4'd5;
  localparam logic [3:0] KIND_STRING    = 4'd6;
  localparam logic [3:0] KIND_NUMBER    = 4'd7;
  localparam logic [3:0] KIND_BOOLEAN   = 4'd8;
  localparam logic [3:0] KIND_NULL      = 4'd9;
  localparam logic [3:0] KIND_END       = 4'd10;
  localparam logic [3:0] KIND_ERROR     = 4'd11;

  // Error codes.
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
  localparam logic [1:0] ERR_BAD_LITERAL  = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

  // Literal kinds.
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  // Characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // One result as it appears on the result ports (last_of_run is added later).
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic        bool_value;
    logic [1:0]  error_code;
  } result_t;

  // All results caused by one text byte.
  typedef struct packed {
    logic [1:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } group_t;

endpackage

`default_nettype wire

FILE: rtl/jts_front.sv
// Scanner front end: classifies one text byte per cycle while accept is high and builds its result group.
// Depends on jts_pkg.
`default_nettype none

module jts_front
  import jts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  output group_t          group_out,
  output logic            group_valid
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_INT  = 3'd2,
    MODE_FRAC = 3'd3,
    MODE_EXP  = 3'd4,
    MODE_EXPD = 3'd5,
    MODE_LIT  = 3'd6
  } mode_t;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  mode_t      scan_mode, scan_mode_next;
  logic [2:0] literal_index, literal_index_next;
  logic [1:0] literal_kind, literal_kind_next;
  pos_t       token_start, token_start_next;
  pos_t       byte_position, byte_position_next;
  logic       error_latched, error_latched_next;

  result_t    cand [4];
  logic [3:0] cand_valid;
  logic [2:0] n;

  pos_t       pos_inc;
  logic       is_digit;
  logic       used;
  logic       err;
  logic       take;
  logic       lit_match;
  logic [2:0] lit_len;
  logic [7:0] lit_char;

  function automatic logic [31:0] out32(input pos_t x);
    logic [63:0] t;
    t = 64'(x);
    return t[31:0];
  endfunction

  function automatic result_t make_res(input logic [3:0] kind, input pos_t off,
                                       input pos_t len, input logic bv,
                                       input logic [1:0] ec);
    result_t r;
    r.kind       = kind;
    r.offset     = out32(off);
    r.length     = out32(len);
    r.bool_value = bv;
    r.error_code = ec;
    return r;
  endfunction

  // Expected letter at a given place of a literal; kind 3 reads as null.
  function automatic logic [7:0] literal_letter(input logic [1:0] kd, input logic [2:0] ix);
    logic [7:0] c;
    c = CH_NUL;
    if (kd == LIT_FALSE) begin
      unique case (ix)
        3'd0: c = CH_LOW_F;
        3'd1: c = CH_LOW_A;
        3'd2: c = CH_LOW_L;
        3'd3: c = CH_LOW_S;
        3'd4: c = CH_LOW_E;
        default: c = CH_NUL;
      endcase
    end else if (kd == LIT_TRUE) begin
      unique case (ix)
        3'd0: c = CH_LOW_T;
        3'd1: c = CH_LOW_R;
        3'd2: c = CH_LOW_U;
        3'd3: c = CH_LOW_E;
        default: c = CH_NUL;
      endcase
    end else begin
      unique case (ix)
        3'd0: c = CH_LOW_N;
        3'd1: c = CH_LOW_U;
        3'd2: c = CH_LOW_L;
        3'd3: c = CH_LOW_L;
        default: c = CH_NUL;
      endcase
    end
    return c;
  endfunction

  assign pos_inc  = byte_position + pos_t'(1);
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign lit_len  = (literal_kind == LIT_FALSE) ? 3'd5 : 3'd4;
  assign lit_char = literal_letter(literal_kind, literal_index);
  assign lit_match = (literal_index < 3'd5) && (text_byte == lit_char);

  always_comb begin
    scan_mode_next     = scan_mode;
    literal_index_next = literal_index;
    literal_kind_next  = literal_kind;
    token_start_next   = token_start;
    byte_position_next = pos_inc;
    error_latched_next = error_latched;
    err                = 1'b0;
    used               = 1'b1;
    take               = 1'b0;
    cand_valid         = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (!error_latched) begin
      unique case (scan_mode)
        MODE_STR: begin
          if (text_byte == CH_QUOTE) begin
            cand[0]        = make_res(KIND_STRING, token_start, byte_position - token_start,
                                      1'b0, ERR_UNEXPECTED);
            cand_valid[0]  = 1'b1;
            scan_mode_next = MODE_IDLE;
          end
        end
        MODE_LIT: begin
          if (lit_match) begin
            literal_index_next = literal_index + 3'd1;
            if ((literal_index + 3'd1) >= lit_len) begin
              cand[0] = make_res((literal_kind == LIT_TRUE || literal_kind == LIT_FALSE)
                                   ? KIND_BOOLEAN : KIND_NULL,
                                 token_start, pos_t'(lit_len),
                                 literal_kind == LIT_TRUE, ERR_UNEXPECTED);
              cand_valid[0]  = 1'b1;
              scan_mode_next = MODE_IDLE;
            end
          end else begin
            error_latched_next = 1'b1;
            err                = 1'b1;
            cand[0]       = make_res(KIND_ERROR, byte_position, '0, 1'b0, ERR_BAD_LITERAL);
            cand_valid[0] = 1'b1;
          end
        end
        MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPD: begin
          // Decide whether the byte continues the open number.
          unique case (scan_mode)
            MODE_INT: begin
              if (is_digit) begin
                take = 1'b1;
              end else if (text_byte == CH_DOT) begin
                take = 1'b1;
                scan_mode_next = MODE_FRAC;
              end else if (text_byte == CH_LOW_E || text_byte == CH_UP_E) begin
                take = 1'b1;
                scan_mode_next = MODE_EXP;
              end
            end
            MODE_FRAC: begin
              if (is_digit) begin
                take = 1'b1;
              end else if (text_byte == CH_LOW_E || text_byte == CH_UP_E) begin
                take = 1'b1;
                scan_mode_next = MODE_EXP;
              end
            end
            MODE_EXP: begin
              if (is_digit || text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                take = 1'b1;
                scan_mode_next = MODE_EXPD;
              end
            end
            default: take = is_digit;
          endcase
          if (!take) begin
            cand[0]        = make_res(KIND_NUMBER, token_start, byte_position - token_start,
                                      1'b0, ERR_UNEXPECTED);
            cand_valid[0]  = 1'b1;
            scan_mode_next = MODE_IDLE;
            used           = 1'b0;
          end
        end
        default: begin
          scan_mode_next = MODE_IDLE;
          used           = 1'b0;
        end
      endcase

      // The byte opens a new token, is skipped as whitespace or latches an error.
      if (!used) begin
        priority if (text_byte == CH_LBRACE || text_byte == CH_RBRACE ||
                     text_byte == CH_LBRACK || text_byte == CH_RBRACK ||
                     text_byte == CH_COLON  || text_byte == CH_COMMA) begin
          priority case (text_byte)
            CH_LBRACE: cand[1].kind = KIND_OBJ_START;
            CH_RBRACE: cand[1].kind = KIND_OBJ_END;
            CH_LBRACK: cand[1].kind = KIND_ARR_START;
            CH_RBRACK: cand[1].kind = KIND_ARR_END;
            CH_COLON:  cand[1].kind = KIND_COLON;
            default:   cand[1].kind = KIND_COMMA;
          endcase
          cand[1].offset = out32(byte_position);
          cand[1].length = 32'd1;
          cand_valid[1]  = 1'b1;
        end else if (text_byte == CH_SPACE ||
                     (text_byte >= CH_TAB && text_byte <= CH_CR)) begin
          scan_mode_next = MODE_IDLE;
        end else if (text_byte == CH_QUOTE) begin
          scan_mode_next   = MODE_STR;
          token_start_next = pos_inc;
        end else if (text_byte == CH_LOW_N || text_byte == CH_LOW_T ||
                     text_byte == CH_LOW_F) begin
          scan_mode_next     = MODE_LIT;
          literal_kind_next  = (text_byte == CH_LOW_N) ? LIT_NULL :
                               (text_byte == CH_LOW_T) ? LIT_TRUE : LIT_FALSE;
          literal_index_next = 3'd1;
          token_start_next   = byte_position;
        end else if (text_byte == CH_MINUS || is_digit) begin
          scan_mode_next   = MODE_INT;
          token_start_next = byte_position;
        end else begin
          error_latched_next = 1'b1;
          err                = 1'b1;
          cand[1]       = make_res(KIND_ERROR, byte_position, '0, 1'b0, ERR_UNEXPECTED);
          cand_valid[1] = 1'b1;
        end
      end
    end

    // Last byte of a document: close what is open, then report end unless the byte raised an error.
    if (final_byte) begin
      if (!error_latched_next) begin
        unique case (scan_mode_next)
          MODE_STR: begin
            err           = 1'b1;
            cand[2]       = make_res(KIND_ERROR, byte_position, '0, 1'b0, ERR_UNTERMINATED);
            cand_valid[2] = 1'b1;
          end
          MODE_LIT: begin
            err           = 1'b1;
            cand[2]       = make_res(KIND_ERROR, byte_position, '0, 1'b0, ERR_BAD_LITERAL);
            cand_valid[2] = 1'b1;
          end
          MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPD: begin
            cand[2]       = make_res(KIND_NUMBER, token_start_next, pos_inc - token_start_next,
                                     1'b0, ERR_UNEXPECTED);
            cand_valid[2] = 1'b1;
          end
          default: ;
        endcase
      end
      if (!err) begin
        cand[3]       = make_res(KIND_END, pos_inc, '0, 1'b0, ERR_UNEXPECTED);
        cand_valid[3] = 1'b1;
      end
      scan_mode_next     = MODE_IDLE;
      literal_index_next = '0;
      literal_kind_next  = LIT_NULL;
      token_start_next   = '0;
      byte_position_next = '0;
      error_latched_next = 1'b0;
    end
  end

  // Pack the valid candidates in order into the group.
  always_comb begin
    group_out = '0;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_valid[i] && n < 3'(MAX_RESULTS)) begin
        group_out.res[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    group_out.count = n[1:0];
    group_valid     = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      literal_index <= '0;
      literal_kind  <= LIT_NULL;
      token_start   <= '0;
      byte_position <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      literal_index <= literal_index_next;
      literal_kind  <= literal_kind_next;
      token_start   <= token_start_next;
      byte_position <= byte_position_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jts_group_fifo.sv
// Short queue of result groups between the scanner front end and the back end.
// Depends on jts_pkg.
`default_nettype none

module jts_group_fifo
  import jts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  group_t      wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output group_t      rd_data,
  output logic        empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  group_t              store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_BITS'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jts_back.sv
// Back end: hands out the results of the head group one at a time.
// Depends on jts_pkg.
`default_nettype none

module jts_back
  import jts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  group_t      head,
  input  wire logic   head_empty,
  output logic        head_pop,
  input  wire logic   pop,
  output logic        empty,
  output result_t     cur,
  output logic        last
);

  logic [1:0] index;
  logic       take;

  assign empty    = head_empty;
  assign cur      = head.res[index];
  assign last     = (index == head.count - 2'd1);
  assign take     = pop && !head_empty;
  assign head_pop = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
    end else if (take) begin
      index <= last ? 2'd0 : index + 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/json_token_scanner_top.sv
// Top level of the JSON token scanner: front end, group queue and back end.
// Depends on jts_pkg, jts_front, jts_group_fifo and jts_back.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ---------------------------------------------
//   input     push / full           text_byte, final_byte
//   result    empty / pop           token_kind, token_offset, token_length,
//                                   bool_value, error_code, last_of_run
//
// The front end takes one text byte in every cycle in which the group queue has
// room, and it writes all results of that byte as one group in the same cycle.
// The back end delivers one result per cycle while pop is high and a group waits, so
// a byte that causes two or three results holds the result side until all are popped;
// the queue of QUEUE_DEPTH groups absorbs such bursts and any stall on the result side.
// A result reaches the result ports from the group queue once the groups ahead are popped.
// Reset is synchronous and active high; it empties the queue and returns the
// scanner to the state between documents.
`default_nettype none

module json_token_scanner_top
  import jts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte,
  input  wire logic        final_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind,
  output logic [31:0]      token_offset,
  output logic [31:0]      token_length,
  output logic             bool_value,
  output logic [1:0]       error_code,
  output logic             last_of_run
);

  // A byte is transferred when push is high and the queue has room.
  logic    accept;
  group_t  front_group;
  logic    front_valid;
  group_t  head_group;
  logic    head_empty;
  logic    head_pop;
  result_t cur;

  assign accept = push && !full;

  jts_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .group_out  (front_group),
    .group_valid(front_valid)
  );

  // Bytes that cause no result never enter the queue.
  jts_group_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_valid),
    .wr_data(front_group),
    .full   (full),
    .rd_en  (head_pop),
    .rd_data(head_group),
    .empty  (head_empty)
  );

  jts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_group),
    .head_empty(head_empty),
    .head_pop  (head_pop),
    .pop       (pop),
    .empty     (empty),
    .cur       (cur),
    .last      (last_of_run)
  );

  assign token_kind   = cur.kind;
  assign token_offset = cur.offset;
  assign token_length = cur.length;
  assign bool_value   = cur.bool_value;
  assign error_code   = cur.error_code;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for json_token_scanner_top: directed byte table, then random documents.
// Depends on jts_pkg (token kinds, error codes, characters, result_t) and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jts_pkg::*;

  // A run stops when no transfer happens on either side for this many cycles.
  localparam int IDLE_LIMIT = 1000;
  // Cycles to keep popping after the last expected token, so that extra tokens show up.
  localparam int DRAIN_CYCLES = 20;
  // Least number of bytes that the scanner actually looks at, per random phase.
  localparam int ITEMS_PER_PHASE = 90;

  // Scanner modes of the token predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_STRING, SCAN_INT, SCAN_FRAC, SCAN_EXP, SCAN_EXP_DIGITS, SCAN_LITERAL
  } scan_mode_t;

  // One token as it leaves the result side, with its end-of-run mark.
  typedef struct packed {
    result_t body;
    logic    last;
  } token_t;

  // One row of byte stimulus. A typed row carries its single expected token
  // written out by hand; every other row is checked against the predictor.
  typedef struct packed {
    logic [7:0] text;
    logic       fin;
    logic       typed;
    token_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  token_kind;
  logic [31:0] token_offset;
  logic [31:0] token_length;
  logic        bool_value;
  logic [1:0]  error_code;
  logic        last_of_run;

  json_token_scanner_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .empty        (empty),
    .pop          (pop),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .bool_value   (bool_value),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatches = 0;
  int quiet_cycles = 0;
  // Bytes taken by the scanner outside a sticky error, and every last byte, counted per phase.
  int live_items = 0;

  token_t    pending_tokens[$];
  stim_row_t directed_rows[$];
  logic [7:0] doc_text[$];

  // ---------------------------------------------------------------------------
  // Token predictor. It keeps its own copy of the scanner state and, for each
  // transferred byte, leaves the tokens that byte causes in byte_tokens.
  // ---------------------------------------------------------------------------
  scan_mode_t  lex_mode;
  logic [2:0]  lit_index;
  logic [1:0]  lit_kind;
  logic [31:0] tok_start;
  logic [31:0] byte_pos;
  logic        err_sticky;
  logic        byte_error;
  token_t      byte_tokens[0:MAX_RESULTS-1];
  int          byte_token_count;

  task automatic reset_lexer();
    lex_mode   = SCAN_IDLE;
    lit_index  = 3'd0;
    lit_kind   = LIT_NULL;
    tok_start  = 32'd0;
    byte_pos   = 32'd0;
    err_sticky = 1'b0;
  endtask

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Letter idx of a literal; the unused fourth kind spells null like kind zero.
  function automatic logic [7:0] literal_char(logic [1:0] kind, logic [2:0] idx);
    case (kind)
      LIT_TRUE: begin
        case (idx)
          3'd0: return CH_LOW_T;
          3'd1: return CH_LOW_R;
          3'd2: return CH_LOW_U;
          3'd3: return CH_LOW_E;
          default: return CH_NUL;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0: return CH_LOW_F;
          3'd1: return CH_LOW_A;
          3'd2: return CH_LOW_L;
          3'd3: return CH_LOW_S;
          3'd4: return CH_LOW_E;
          default: return CH_NUL;
        endcase
      end
      default: begin
        case (idx)
          3'd0: return CH_LOW_N;
          3'd1: return CH_LOW_U;
          3'd2, 3'd3: return CH_LOW_L;
          default: return CH_NUL;
        endcase
      end
    endcase
  endfunction

  function automatic int literal_length(logic [1:0] kind);
    return (kind == LIT_FALSE) ? 5 : 4;
  endfunction

  // Mode after byte b inside an open number, or SCAN_IDLE when b ends it.
  function automatic scan_mode_t number_next(scan_mode_t m, logic [7:0] b);
    case (m)
      SCAN_INT: begin
        if (is_digit(b)) return SCAN_INT;
        if (b == CH_DOT) return SCAN_FRAC;
        if (b == CH_LOW_E || b == CH_UP_E) return SCAN_EXP;
        return SCAN_IDLE;
      end
      SCAN_FRAC: begin
        if (is_digit(b)) return SCAN_FRAC;
        if (b == CH_LOW_E || b == CH_UP_E) return SCAN_EXP;
        return SCAN_IDLE;
      end
      SCAN_EXP: begin
        if (is_digit(b) || b == CH_PLUS || b == CH_MINUS) return SCAN_EXP_DIGITS;
        return SCAN_IDLE;
      end
      default: return is_digit(b) ? SCAN_EXP_DIGITS : SCAN_IDLE;
    endcase
  endfunction

  task automatic add_token(logic [3:0] kind, logic [31:0] off, logic [31:0] len, logic bv,
                           logic [1:0] code);
    token_t t;
    t.body.kind       = kind;
    t.body.offset     = off;
    t.body.length     = len;
    t.body.bool_value = bv;
    t.body.error_code = code;
    t.last            = 1'b0;
    if (byte_token_count < MAX_RESULTS) begin
      byte_tokens[byte_token_count] = t;
      byte_token_count++;
    end
  endtask

  // Byte b seen between tokens: punctuation, whitespace, or the start of a token.
  // Anything else is an unexpected character and latches the error.
  task automatic open_token(logic [7:0] b, logic [31:0] pos);
    case (b)
      CH_LBRACE: add_token(KIND_OBJ_START, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_RBRACE: add_token(KIND_OBJ_END, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_LBRACK: add_token(KIND_ARR_START, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_RBRACK: add_token(KIND_ARR_END, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_COLON:  add_token(KIND_COLON, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_COMMA:  add_token(KIND_COMMA, pos, 32'd1, 1'b0, ERR_UNEXPECTED);
      CH_QUOTE: begin
        lex_mode  = SCAN_STRING;
        tok_start = pos + 32'd1;
      end
      CH_LOW_N, CH_LOW_T, CH_LOW_F: begin
        lex_mode  = SCAN_LITERAL;
        lit_kind  = (b == CH_LOW_N) ? LIT_NULL : (b == CH_LOW_T) ? LIT_TRUE : LIT_FALSE;
        lit_index = 3'd1;
        tok_start = pos;
      end
      default: begin
        if (b == CH_MINUS || is_digit(b)) begin
          lex_mode  = SCAN_INT;
          tok_start = pos;
        end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
          err_sticky = 1'b1;
          byte_error = 1'b1;
          add_token(KIND_ERROR, pos, 32'd0, 1'b0, ERR_UNEXPECTED);
        end
      end
    endcase
  endtask

  task automatic lex_byte(logic [7:0] b, logic fin);
    logic [31:0] pos;
    logic        used;
    scan_mode_t  nxt;
    pos = byte_pos;
    used = 1'b1;
    byte_error = 1'b0;
    byte_token_count = 0;
    if (!err_sticky) begin
      case (lex_mode)
        SCAN_STRING: begin
          if (b == CH_QUOTE) begin
            add_token(KIND_STRING, tok_start, pos - tok_start, 1'b0, ERR_UNEXPECTED);
            lex_mode = SCAN_IDLE;
          end
        end
        SCAN_LITERAL: begin
          if (lit_index < 3'd5 && b == literal_char(lit_kind, lit_index)) begin
            lit_index = lit_index + 3'd1;
            if (lit_index >= literal_length(lit_kind)) begin
              add_token((lit_kind == LIT_TRUE || lit_kind == LIT_FALSE) ? KIND_BOOLEAN : KIND_NULL,
                        tok_start, 32'(literal_length(lit_kind)), lit_kind == LIT_TRUE,
                        ERR_UNEXPECTED);
              lex_mode = SCAN_IDLE;
            end
          end else begin
            err_sticky = 1'b1;
            byte_error = 1'b1;
            add_token(KIND_ERROR, pos, 32'd0, 1'b0, ERR_BAD_LITERAL);
          end
        end
        SCAN_INT, SCAN_FRAC, SCAN_EXP, SCAN_EXP_DIGITS: begin
          // A byte that does not continue the number closes it and is then
          // scanned again as the start of the next token.
          nxt = number_next(lex_mode, b);
          if (nxt == SCAN_IDLE) begin
            add_token(KIND_NUMBER, tok_start, pos - tok_start, 1'b0, ERR_UNEXPECTED);
            used = 1'b0;
          end
          lex_mode = nxt;
        end
        default: begin
          lex_mode = SCAN_IDLE;
          used = 1'b0;
        end
      endcase
      if (!used) open_token(b, pos);
    end

    if (fin) begin
      // The last byte closes whatever is open; an error here replaces end.
      if (!err_sticky) begin
        if (lex_mode == SCAN_STRING) begin
          byte_error = 1'b1;
          add_token(KIND_ERROR, pos, 32'd0, 1'b0, ERR_UNTERMINATED);
        end else if (lex_mode == SCAN_LITERAL) begin
          byte_error = 1'b1;
          add_token(KIND_ERROR, pos, 32'd0, 1'b0, ERR_BAD_LITERAL);
        end else if (lex_mode >= SCAN_INT && lex_mode <= SCAN_EXP_DIGITS) begin
          add_token(KIND_NUMBER, tok_start, pos + 32'd1 - tok_start, 1'b0, ERR_UNEXPECTED);
        end
      end
      if (!byte_error) add_token(KIND_END, pos + 32'd1, 32'd0, 1'b0, ERR_UNEXPECTED);
      reset_lexer();
    end else begin
      byte_pos = pos + 32'd1;
    end

    if (byte_token_count > 0) byte_tokens[byte_token_count - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------
  task automatic add_row(logic [7:0] b, logic fin);
    stim_row_t row;
    row.text  = b;
    row.fin   = fin;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0);
  endtask

  // A row whose byte causes exactly one token, given here by hand.
  task automatic add_typed(logic [7:0] b, logic fin, logic [3:0] kind, logic [31:0] off,
                           logic [31:0] len, logic [1:0] code);
    stim_row_t row;
    row.text                 = b;
    row.fin                  = fin;
    row.typed                = 1'b1;
    row.want.body.kind       = kind;
    row.want.body.offset     = off;
    row.want.body.length     = len;
    row.want.body.bool_value = 1'b0;
    row.want.body.error_code = code;
    row.want.last            = 1'b1;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random documents. Most are well formed with random content; some carry a
  // stray byte, an open string or a cut-off literal at the end.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic append_number();
    int start_size;
    start_size = doc_text.size();
    if ($urandom_range(0, 2) == 0) doc_text.push_back(CH_MINUS);
    repeat ($urandom_range(0, 3)) doc_text.push_back(random_digit());
    if ($urandom_range(0, 1) == 1) begin
      doc_text.push_back(CH_DOT);
      repeat ($urandom_range(0, 2)) doc_text.push_back(random_digit());
    end
    if ($urandom_range(0, 1) == 1) begin
      doc_text.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
      case ($urandom_range(0, 2))
        0: doc_text.push_back(CH_PLUS);
        1: doc_text.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) doc_text.push_back(random_digit());
    end
    if (doc_text.size() == start_size) doc_text.push_back(random_digit());
  endtask

  task automatic append_token();
    int r;
    logic [1:0] kind;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 5))
        0: doc_text.push_back(CH_LBRACE);
        1: doc_text.push_back(CH_RBRACE);
        2: doc_text.push_back(CH_LBRACK);
        3: doc_text.push_back(CH_RBRACK);
        4: doc_text.push_back(CH_COLON);
        default: doc_text.push_back(CH_COMMA);
      endcase
    end else if (r < 45) begin
      // String content is mostly printable, now and then any byte but a quote.
      doc_text.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(32, 126));
        if (b != CH_QUOTE) doc_text.push_back(b);
      end
      doc_text.push_back(CH_QUOTE);
    end else if (r < 68) begin
      append_number();
    end else if (r < 85) begin
      kind = 2'($urandom_range(0, 2));
      for (int i = 0; i < literal_length(kind); i++) begin
        doc_text.push_back(literal_char(kind, 3'(i)));
      end
    end else begin
      b = ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
      doc_text.push_back(b);
    end
  endtask

  task automatic make_document();
    int r;
    logic [1:0] kind;
    doc_text.delete();
    repeat ($urandom_range(1, 10)) append_token();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      doc_text[$urandom_range(0, doc_text.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 18) begin
      doc_text.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) doc_text.push_back(8'($urandom_range(32, 126)));
    end else if (r < 24) begin
      kind = 2'($urandom_range(0, 2));
      doc_text.push_back(literal_char(kind, 3'd0));
      if ($urandom_range(0, 1) == 1) doc_text.push_back(literal_char(kind, 3'd1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge; a transfer is seen on the rising
  // edge at which push is high and full is low. The task starts and ends at a
  // falling edge, so push stays high between back-to-back bytes.
  // ---------------------------------------------------------------------------
  task automatic send_row(stim_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    text_byte  <= row.text;
    final_byte <= row.fin;
    @(posedge clk);
    while (full) @(posedge clk);
    if (!err_sticky || row.fin) live_items++;
    lex_byte(row.text, row.fin);
    if (row.typed) begin
      pending_tokens.push_back(row.want);
    end else begin
      for (int i = 0; i < byte_token_count; i++) pending_tokens.push_back(byte_tokens[i]);
    end
    @(negedge clk);
  endtask

  task automatic send_document();
    stim_row_t row;
    for (int i = 0; i < doc_text.size(); i++) begin
      row.text  = doc_text[i];
      row.fin   = (i == doc_text.size() - 1);
      row.typed = 1'b0;
      row.want  = '0;
      send_row(row);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop is drawn on each falling edge, and every transfer on the
  // result side is checked against the oldest pending token.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    token_t want;
    if (!rst && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: token with nothing expected, kind %0d offset %0d length %0d",
                 $time, token_kind, token_offset, token_length);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 32'(want.body.kind), 32'(token_kind));
        check_field("token_offset", want.body.offset, token_offset);
        check_field("token_length", want.body.length, token_length);
        check_field("bool_value", 32'(want.body.bool_value), 32'(bool_value));
        check_field("error_code", 32'(want.body.error_code), 32'(error_code));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run));
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side means a hang.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d tokens still pending",
               $time, IDLE_LIMIT, pending_tokens.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_lexer();

    // Object with an empty string key and a number that passes through every
    // number mode; the comma both closes the number and is a token itself.
    // The last byte opens an array, so it gives the bracket and then end.
    add_typed(CH_LBRACE, 1'b0, KIND_OBJ_START, 32'd0, 32'd1, ERR_UNEXPECTED);
    add_text("\"\":-.E7,");
    add_row(CH_LBRACK, 1'b1);
    // null, then a number that the last byte closes: number, brace and end.
    add_text("null9");
    add_row(CH_RBRACE, 1'b1);
    // A literal that completes on the last byte.
    add_text("tru");
    add_row(CH_LOW_E, 1'b1);
    // Wrong letter of a literal on the last byte: the error takes the place of end.
    add_row(CH_LOW_F, 1'b0);
    add_typed(8'hFF, 1'b1, KIND_ERROR, 32'd1, 32'd0, ERR_BAD_LITERAL);
    // Unexpected character; the error is sticky, so the last byte gives end only.
    // Tokens other than error carry error code zero.
    add_typed(CH_NUL, 1'b0, KIND_ERROR, 32'd0, 32'd0, ERR_UNEXPECTED);
    add_typed(CH_LOW_A, 1'b1, KIND_END, 32'd2, 32'd0, ERR_UNEXPECTED);
    // String still open at the last byte.
    add_row(CH_QUOTE, 1'b0);
    add_typed(8'hFF, 1'b1, KIND_ERROR, 32'd1, 32'd0, ERR_UNTERMINATED);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      live_items = 0;
      while (live_items < ITEMS_PER_PHASE) begin
        make_document();
        send_document();
      end
    end
    push <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/jts_pkg.sv
rtl/jts_front.sv
rtl/jts_group_fifo.sv
rtl/jts_back.sv
rtl/json_token_scanner_top.sv
test/testbench.sv
